[sv/cbpg_pkg.sv]
package cbpg_pkg;

   // Curve and parameter arithmetic
   localparam int MAX_POINTS      = 64;
   localparam int PARAM_FRAC_BITS = 16;
   localparam int COORD_W         = 32;
   localparam int COUNT_W         = 7;
   localparam int INDEX_W         = 6;

   localparam int PARAM_W   = PARAM_FRAC_BITS + 1;      // t in Q1.PARAM_FRAC_BITS
   localparam int DIV_W     = $clog2(MAX_POINTS);       // holds point count minus one
   localparam int DIVCNT_W  = $clog2(PARAM_W);
   localparam int MUL_A_W   = PARAM_W + 1;              // weight, signed operand
   localparam int PROD_W    = MUL_A_W + COORD_W;
   localparam int WPROD_W   = 2 * PARAM_W + 2;          // weight product times three
   localparam int ACC_W     = PROD_W + 2;               // sum of four products
   localparam int SHIFT_W   = ACC_W - PARAM_FRAC_BITS;

   localparam logic [PARAM_W-1:0] PARAM_ONE  = PARAM_W'(1) << PARAM_FRAC_BITS;
   localparam logic [PARAM_W-1:0] PARAM_HALF = PARAM_W'(1) << (PARAM_FRAC_BITS - 1);

   typedef struct packed {
      logic signed [COORD_W-1:0] p0_x;
      logic signed [COORD_W-1:0] p0_y;
      logic signed [COORD_W-1:0] p1_x;
      logic signed [COORD_W-1:0] p1_y;
      logic signed [COORD_W-1:0] p2_x;
      logic signed [COORD_W-1:0] p2_y;
      logic signed [COORD_W-1:0] p3_x;
      logic signed [COORD_W-1:0] p3_y;
      logic [COUNT_W-1:0]        point_count;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0]        point_index;
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic                      last_point;
   } rsp_type;

   // Multiply schedule of one point, in issue order
   typedef enum logic [3:0] {
      OP_T2 = 4'd0,
      OP_U2 = 4'd1,
      OP_W3 = 4'd2,
      OP_W2 = 4'd3,
      OP_W0 = 4'd4,
      OP_W1 = 4'd5,
      OP_X0 = 4'd6,
      OP_X1 = 4'd7,
      OP_X2 = 4'd8,
      OP_X3 = 4'd9,
      OP_Y0 = 4'd10,
      OP_Y1 = 4'd11,
      OP_Y2 = 4'd12,
      OP_Y3 = 4'd13
   } mul_op_type;

   typedef struct packed {
      logic       load_req;
      logic       div_step;
      logic       point_setup;
      logic       mul_valid;
      mul_op_type mul_op;
      logic       load_rsp;
      logic       advance;
   } ctrl_cmd_type;

   typedef struct packed {
      logic div_done;
      logic last_point;
      logic rsp_free;
   } dp_status_type;

endpackage

[sv/cbpg_ctrl.sv]
module cbpg_ctrl
   import cbpg_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_DIVIDE   = 6'b000010,
      ST_SETUP    = 6'b000100,
      ST_MULTIPLY = 6'b001000,
      ST_DRAIN    = 6'b010000,
      ST_EMIT     = 6'b100000
   } state_type;

   state_type                     state_ff, state_in;
   logic [$bits(mul_op_type)-1:0] step_ff, step_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      cmd        = '0;
      cmd.mul_op = OP_T2;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.point_setup = 1'b1;
            step_in         = '0;
            state_in        = ST_MULTIPLY;
         end
         ST_MULTIPLY: begin
            cmd.mul_valid = 1'b1;
            cmd.mul_op    = mul_op_type'(step_ff);
            if (step_ff == OP_Y3) begin
               state_in = ST_DRAIN;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         // let the last product reach the accumulator
         ST_DRAIN: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               if (status.last_point) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = ST_SETUP;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

[sv/cbpg_datapath.sv]
module cbpg_datapath
   import cbpg_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  req_type       req_data,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp_data
);

   // held request
   req_type            pts_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [DIV_W-1:0]   divisor_ff;

   // run state
   logic [INDEX_W-1:0]  index_ff;
   logic [PARAM_W-1:0]  param_ff;
   logic [PARAM_W-1:0]  param_step_ff;   // dividend, shifted into the quotient
   logic [DIV_W-1:0]    div_rem_ff;
   logic [DIVCNT_W-1:0] div_cnt_ff;

   // weights
   logic [PARAM_W-1:0] t_ff, u_ff, t2_ff, u2_ff;
   logic [PARAM_W-1:0] w0_ff, w1_ff, w2_ff, w3_ff;

   // multiplier and accumulators
   logic signed [PROD_W-1:0] prod_ff;
   mul_op_type               op_q_ff;
   logic                     post_valid_ff;
   logic signed [ACC_W-1:0]  acc_x_ff, acc_y_ff;

   logic                     rsp_valid_ff;
   rsp_type                  rsp_data_ff;

   logic [COUNT_W-1:0]        count_in;
   logic [COUNT_W-1:0]        count_m1;
   logic                      last_point;
   logic [DIV_W:0]            trial;
   logic                      trial_ge;
   logic [PARAM_W:0]          param_sum;
   logic [PARAM_W-1:0]        mul_a_u;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [COORD_W-1:0] mul_b;
   logic [WPROD_W-1:0]        wprod;
   logic [WPROD_W-1:0]        wsum;
   logic [WPROD_W-1:0]        wrnd_full;
   logic [PARAM_W-1:0]        wrnd;
   logic signed [ACC_W-1:0]   prod_ext;
   logic [ACC_W-1:0]          sum_x, sum_y;
   logic signed [COORD_W-1:0] sat_x, sat_y;

   function automatic logic signed [COORD_W-1:0] saturate(input logic [SHIFT_W-1:0] v);
      logic [SHIFT_W-COORD_W:0] top;
      logic signed [COORD_W-1:0] r;
      top = v[SHIFT_W-1:COORD_W-1];
      if ((top == '0) || (top == '1)) begin
         r = v[COORD_W-1:0];
      end else if (v[SHIFT_W-1]) begin
         r = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(COORD_W-1){1'b1}}};
      end
      return r;
   endfunction

   // clamp the count to 1..MAX_POINTS
   always_comb begin
      count_in = req_data.point_count;
      if (count_in == '0) begin
         count_in = COUNT_W'(1);
      end else if (count_in > COUNT_W'(MAX_POINTS)) begin
         count_in = COUNT_W'(MAX_POINTS);
      end
   end

   assign count_m1   = count_ff - 1'b1;
   assign last_point = (index_ff == INDEX_W'(count_m1));

   // restoring divider, one quotient bit per cycle
   assign trial    = {div_rem_ff, param_step_ff[PARAM_W-1]};
   assign trial_ge = (trial >= {1'b0, divisor_ff});

   assign param_sum = {1'b0, param_ff} + {1'b0, param_step_ff};

   always_comb begin
      mul_a_u = '0;
      mul_b   = '0;
      unique case (cmd.mul_op)
         OP_T2: begin mul_a_u = t_ff;  mul_b = COORD_W'(t_ff); end
         OP_U2: begin mul_a_u = u_ff;  mul_b = COORD_W'(u_ff); end
         OP_W3: begin mul_a_u = t2_ff; mul_b = COORD_W'(t_ff); end
         OP_W2: begin mul_a_u = t2_ff; mul_b = COORD_W'(u_ff); end
         OP_W0: begin mul_a_u = u2_ff; mul_b = COORD_W'(u_ff); end
         OP_W1: begin mul_a_u = u2_ff; mul_b = COORD_W'(t_ff); end
         OP_X0: begin mul_a_u = w0_ff; mul_b = pts_ff.p0_x; end
         OP_X1: begin mul_a_u = w1_ff; mul_b = pts_ff.p1_x; end
         OP_X2: begin mul_a_u = w2_ff; mul_b = pts_ff.p2_x; end
         OP_X3: begin mul_a_u = w3_ff; mul_b = pts_ff.p3_x; end
         OP_Y0: begin mul_a_u = w0_ff; mul_b = pts_ff.p0_y; end
         OP_Y1: begin mul_a_u = w1_ff; mul_b = pts_ff.p1_y; end
         OP_Y2: begin mul_a_u = w2_ff; mul_b = pts_ff.p2_y; end
         OP_Y3: begin mul_a_u = w3_ff; mul_b = pts_ff.p3_y; end
         default: begin mul_a_u = '0; mul_b = '0; end
      endcase
   end

   assign mul_a = {1'b0, mul_a_u};

   // weight rounding; the 3t(1-t) terms are tripled first
   assign wprod     = prod_ff[WPROD_W-1:0];
   assign wsum      = ((op_q_ff == OP_W2) || (op_q_ff == OP_W1)) ? wprod + (wprod << 1) : wprod;
   assign wrnd_full = wsum + WPROD_W'(PARAM_HALF);
   assign wrnd      = wrnd_full[PARAM_FRAC_BITS +: PARAM_W];

   assign prod_ext = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};

   // round half up, floor shift, saturate
   assign sum_x = acc_x_ff + ACC_W'(PARAM_HALF);
   assign sum_y = acc_y_ff + ACC_W'(PARAM_HALF);
   assign sat_x = saturate(sum_x[ACC_W-1:PARAM_FRAC_BITS]);
   assign sat_y = saturate(sum_y[ACC_W-1:PARAM_FRAC_BITS]);

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         pts_ff     <= req_data;
         count_ff   <= count_in;
         divisor_ff <= DIV_W'(count_in - 1'b1);
      end

      if (cmd.point_setup) begin
         if (last_point && (count_ff != COUNT_W'(1))) begin
            t_ff <= PARAM_ONE;
            u_ff <= '0;
         end else if (param_ff > PARAM_ONE) begin
            t_ff <= PARAM_ONE;
            u_ff <= '0;
         end else begin
            t_ff <= param_ff;
            u_ff <= PARAM_ONE - param_ff;
         end
      end

      if (cmd.mul_valid) begin
         prod_ff <= mul_a * mul_b;
         op_q_ff <= cmd.mul_op;
      end

      if (post_valid_ff) begin
         unique case (op_q_ff)
            OP_T2: t2_ff <= wrnd;
            OP_U2: u2_ff <= wrnd;
            OP_W3: w3_ff <= wrnd;
            OP_W2: w2_ff <= wrnd;
            OP_W0: w0_ff <= wrnd;
            OP_W1: w1_ff <= wrnd;
            OP_X0: acc_x_ff <= prod_ext;
            OP_X1, OP_X2, OP_X3: acc_x_ff <= acc_x_ff + prod_ext;
            OP_Y0: acc_y_ff <= prod_ext;
            OP_Y1, OP_Y2, OP_Y3: acc_y_ff <= acc_y_ff + prod_ext;
            default: begin
            end
         endcase
      end

      if (cmd.load_rsp) begin
         rsp_data_ff.point_index <= index_ff;
         rsp_data_ff.point_x     <= sat_x;
         rsp_data_ff.point_y     <= sat_y;
         rsp_data_ff.last_point  <= last_point;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff      <= '0;
         param_ff      <= '0;
         param_step_ff <= '0;
         div_rem_ff    <= '0;
         div_cnt_ff    <= '0;
         post_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         post_valid_ff <= cmd.mul_valid;

         if (cmd.load_req) begin
            index_ff      <= '0;
            param_ff      <= '0;
            param_step_ff <= PARAM_ONE + PARAM_W'(DIV_W'(count_in - 1'b1) >> 1);
            div_rem_ff    <= '0;
            div_cnt_ff    <= '0;
         end else if (cmd.div_step) begin
            div_rem_ff    <= trial_ge ? DIV_W'(trial - {1'b0, divisor_ff}) : trial[DIV_W-1:0];
            param_step_ff <= {param_step_ff[PARAM_W-2:0], trial_ge};
            div_cnt_ff    <= div_cnt_ff + 1'b1;
         end

         if (cmd.advance) begin
            index_ff <= index_ff + 1'b1;
            param_ff <= (param_sum > {1'b0, PARAM_ONE}) ? PARAM_ONE : param_sum[PARAM_W-1:0];
         end else if (cmd.load_rsp) begin
            // run finished: rewind
            index_ff <= '0;
            param_ff <= '0;
         end

         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.div_done   = (div_cnt_ff == DIVCNT_W'(PARAM_W - 1));
   assign status.last_point = last_point;
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[sv/cubic_bezier_point_generator.sv]
// Channel  Ports                          Transaction
// request  req_valid/req_ready/req_data   four control points and a point count
// response rsp_valid/rsp_ready/rsp_data   one curve point, last_point on the final one
//
// A request is accepted and then passes through the bit-serial step divider.
// Each point then goes through one setup, 14 products through the single
// 18x32 multiplier, one drain and one load of the output register.
// req_ready is high only when idle.
// Reset is synchronous and clears the controller, counters and valid flags.
// A stalled response holds the run in the output stage until it is taken.
module cubic_bezier_point_generator
   import cbpg_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   cbpg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cbpg_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef ASSERT_OFF
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request channel still ready after accepting a transaction");

   a_busy_mid_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_point |-> !req_ready)
      else $error("request accepted while a run is still in progress");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> status.rsp_free)
      else $error("output register overwritten while holding a point");

   a_single_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_req, cmd.div_step, cmd.point_setup, cmd.mul_valid, cmd.load_rsp}))
      else $error("controller issued conflicting commands");
`endif

endmodule
